FILE: hdl/dsg_pkg.sv
// shared constants, types and tables for the digital sinc sample generator
`default_nettype none
package dsg_pkg;

    localparam int ORDER_W   = 6;
    localparam int INDEX_W   = 9;
    localparam int VALUE_W   = 16;
    localparam int CFG_IDX_W = 1;

    localparam int DEF_MAX_ORDER = 32;
    localparam int DEF_FRAC_BITS = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_ORDER        = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFTED_MODE = 1'd1;

    localparam int Q      = 30;
    localparam int X_W    = 31;
    localparam int X2_W   = 32;
    localparam int R_W    = 31;
    localparam int KK_W   = 7;
    localparam int N4_W   = 8;
    localparam int ANG_W  = 39;
    localparam int XQ_W   = 32;
    localparam int DEN_W  = 37;
    localparam int HQ_W   = 30;
    localparam int HC_W   = 9;
    localparam int HORNER_STEPS = 8;

    localparam logic [31:0]    PI_Q30         = 32'd3373259426;
    localparam logic [R_W-1:0] ONE_Q30        = 31'h4000_0000;
    localparam logic [R_W-1:0] HALF_SQRT2_Q30 = 31'd759250125;

    typedef struct packed {
        logic [ORDER_W-1:0] n;
        logic [2:0]         idx;
        logic               den_neg;
        logic               special;
        logic               spec_neg;
        logic               flip;
        logic               oor;
        logic               den_zero;
    } t_side;

    // magnitude of sin(k*pi/4)
    function automatic logic [R_W-1:0] num_mag(input logic [2:0] idx);
        logic [R_W-1:0] v;
        case (idx)
            3'd0, 3'd4: v = '0;
            3'd2, 3'd6: v = ONE_Q30;
            default:    v = HALF_SQRT2_Q30;
        endcase
        return v;
    endfunction

    function automatic logic num_neg(input logic [2:0] idx);
        return idx >= 3'd5;
    endfunction

    function automatic logic [HC_W-1:0] horner_div(input int step);
        logic [HC_W-1:0] v;
        case (step)
            0:       v = 9'd272;
            1:       v = 9'd210;
            2:       v = 9'd156;
            3:       v = 9'd110;
            4:       v = 9'd72;
            5:       v = 9'd42;
            6:       v = 9'd20;
            default: v = 9'd6;
        endcase
        return v;
    endfunction

    // floor(2^32 / horner_div)
    function automatic logic [HQ_W-1:0] horner_recip(input int step);
        logic [HQ_W-1:0] v;
        case (step)
            0:       v = 30'd15790320;
            1:       v = 30'd20452225;
            2:       v = 30'd27531841;
            3:       v = 30'd39045157;
            4:       v = 30'd59652323;
            5:       v = 30'd102261126;
            6:       v = 30'd214748364;
            default: v = 30'd715827882;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/dsg_req_if.sv
// request channel carrying the sample index
`default_nettype none
interface dsg_req_if;
    logic                        valid;
    logic                        ready;
    logic [dsg_pkg::INDEX_W-1:0] sample_index;

    modport source (output valid, output sample_index, input ready);
    modport sink   (input valid, input sample_index, output ready);
endinterface
`default_nettype wire

FILE: hdl/dsg_rsp_if.sv
// response channel carrying the kernel sample
`default_nettype none
interface dsg_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [dsg_pkg::VALUE_W-1:0] sample_value;
    logic                        index_out_of_range;

    modport source (output valid, output sample_value, output index_out_of_range, input ready);
    modport sink   (input valid, input sample_value, input index_out_of_range, output ready);
endinterface
`default_nettype wire

FILE: hdl/digital_sinc_sample_generator_core.sv
// digital sinc (dirichlet kernel) sample generator, top level
//
//  channel   dir  handshake      payload
//  i_req     in   valid/ready    sample_index
//  o_rsp     out  valid/ready    sample_value, index_out_of_range
//  i_cfg_*   in   write enable   order, shifted_mode
//
// one request per cycle while the skid register is empty; the pipeline runs through the angle divider,
// eight three-stage horner steps of the sine and the bit-per-stage final divider
// synchronous active-low reset clears valid bits and sets the order and shifted_mode registers to 1
// output register plus skid register; input ready is the skid register being empty
`default_nettype none
module digital_sinc_sample_generator_core #(
    parameter int MAX_ORDER = dsg_pkg::DEF_MAX_ORDER,
    parameter int FRAC_BITS = dsg_pkg::DEF_FRAC_BITS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [dsg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [dsg_pkg::ORDER_W-1:0]     i_cfg_wdata,
    dsg_req_if.sink                              i_req,
    dsg_rsp_if.source                            o_rsp
);
    localparam int MAG_W  = FRAC_BITS + 1;
    localparam int FMT_W  = (MAG_W > dsg_pkg::VALUE_W) ? MAG_W : dsg_pkg::VALUE_W;
    localparam int MNUM_W = ((dsg_pkg::R_W + FRAC_BITS) > dsg_pkg::DEN_W
                            ? dsg_pkg::R_W + FRAC_BITS : dsg_pkg::DEN_W) + 1;
    localparam logic [MAG_W-1:0] MAG_ONE = MAG_W'(1) << FRAC_BITS;
    localparam int HS = dsg_pkg::HORNER_STEPS;

    logic [dsg_pkg::ORDER_W-1:0] r_order;
    logic                        r_shifted_mode;
    logic                        en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order        <= dsg_pkg::ORDER_W'(1);
            r_shifted_mode <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                dsg_pkg::CFG_ORDER:        r_order        <= i_cfg_wdata;
                dsg_pkg::CFG_SHIFTED_MODE: r_shifted_mode <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // front end
    logic                        f_valid;
    dsg_pkg::t_side              f_side;
    logic [dsg_pkg::ANG_W-1:0]   f_ang;
    logic [dsg_pkg::N4_W-1:0]    f_n4;

    dsg_front #(.MAX_ORDER(MAX_ORDER)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_valid        (i_req.valid),
        .i_sample_index (i_req.sample_index),
        .i_order        (r_order),
        .i_shifted_mode (r_shifted_mode),
        .o_valid        (f_valid),
        .o_side         (f_side),
        .o_ang          (f_ang),
        .o_n4           (f_n4)
    );

    // angle x = pi*k/(4n) in q30
    logic                        a_valid;
    dsg_pkg::t_side              a_side;
    logic [dsg_pkg::XQ_W-1:0]    a_quo;

    dsg_div_pipe #(
        .NUM_W (dsg_pkg::ANG_W),
        .DEN_W (dsg_pkg::N4_W),
        .QUO_W (dsg_pkg::XQ_W),
        .STEPS (4)
    ) u_ang_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_side  (f_side),
        .i_num   (f_ang),
        .i_den   (f_n4),
        .o_valid (a_valid),
        .o_side  (a_side),
        .o_quo   (a_quo)
    );

    // x squared
    logic [dsg_pkg::X_W-1:0]     a_x;
    logic [2*dsg_pkg::X_W-1:0]   p_xx;
    logic                        r_x2_valid;
    dsg_pkg::t_side              r_x2_side;
    logic [dsg_pkg::X_W-1:0]     r_x;
    logic [dsg_pkg::X2_W-1:0]    r_x2;

    assign a_x  = a_quo[dsg_pkg::X_W-1:0];
    assign p_xx = (2*dsg_pkg::X_W)'(a_x) * (2*dsg_pkg::X_W)'(a_x);

    // horner chain
    logic [HS:0]                 h_valid;
    dsg_pkg::t_side              h_side [HS+1];
    logic [dsg_pkg::X_W-1:0]     h_x    [HS+1];
    logic [dsg_pkg::X2_W-1:0]    h_x2   [HS+1];
    logic [dsg_pkg::R_W-1:0]     h_r    [HS+1];

    assign h_valid[0] = r_x2_valid;
    assign h_side[0]  = r_x2_side;
    assign h_x[0]     = r_x;
    assign h_x2[0]    = r_x2;
    assign h_r[0]     = dsg_pkg::ONE_Q30;

    for (genvar g = 0; g < HS; g++) begin : g_horner
        dsg_horner #(.STEP(g)) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (h_valid[g]),
            .i_side  (h_side[g]),
            .i_x     (h_x[g]),
            .i_x2    (h_x2[g]),
            .i_r     (h_r[g]),
            .o_valid (h_valid[g+1]),
            .o_side  (h_side[g+1]),
            .o_x     (h_x[g+1]),
            .o_x2    (h_x2[g+1]),
            .o_r     (h_r[g+1])
        );
    end

    // sine, denominator, dividend
    logic [dsg_pkg::X_W+dsg_pkg::R_W-1:0] p_xr;
    logic                        r_s_valid, r_d_valid, r_m_valid;
    dsg_pkg::t_side              r_s_side, r_d_side, r_m_side, d_side;
    logic [dsg_pkg::R_W-1:0]     r_sin;
    logic [dsg_pkg::DEN_W-1:0]   n_den, r_den, r_m_den;
    logic [MNUM_W-1:0]           r_mnum;

    assign p_xr  = (dsg_pkg::X_W+dsg_pkg::R_W)'(h_x[HS])
                 * (dsg_pkg::X_W+dsg_pkg::R_W)'(h_r[HS]);
    assign n_den = dsg_pkg::DEN_W'(r_s_side.n) * dsg_pkg::DEN_W'(r_sin);

    always_comb begin
        d_side          = r_s_side;
        d_side.den_zero = (n_den == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x2_valid <= 1'b0;
            r_s_valid  <= 1'b0;
            r_d_valid  <= 1'b0;
            r_m_valid  <= 1'b0;
        end else if (en) begin
            r_x2_valid <= a_valid;
            r_s_valid  <= h_valid[HS];
            r_d_valid  <= r_s_valid;
            r_m_valid  <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x2_side <= a_side;
            r_x       <= a_x;
            r_x2      <= p_xx[dsg_pkg::Q +: dsg_pkg::X2_W];
            r_s_side  <= h_side[HS];
            r_sin     <= p_xr[dsg_pkg::Q +: dsg_pkg::R_W];
            r_d_side  <= d_side;
            r_den     <= n_den;
            r_m_side  <= r_d_side;
            r_m_den   <= r_den;
            r_mnum    <= (MNUM_W'(dsg_pkg::num_mag(r_d_side.idx)) << FRAC_BITS)
                       + MNUM_W'(r_den >> 1);
        end
    end

    // magnitude division
    logic                        q_valid;
    dsg_pkg::t_side              q_side;
    logic [MAG_W-1:0]            q_quo;

    dsg_div_pipe #(
        .NUM_W (MNUM_W),
        .DEN_W (dsg_pkg::DEN_W),
        .QUO_W (MAG_W),
        .STEPS (1)
    ) u_mag_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_m_valid),
        .i_side  (r_m_side),
        .i_num   (r_mnum),
        .i_den   (r_m_den),
        .o_valid (q_valid),
        .o_side  (q_side),
        .o_quo   (q_quo)
    );

    // sign, saturation, out of range
    logic [MAG_W-1:0]            mag, clip;
    logic                        neg;
    logic [FMT_W-1:0]            wide;
    logic [dsg_pkg::VALUE_W-1:0] n_value;
    logic                        fire;

    always_comb begin
        if (q_side.special) begin
            mag = MAG_ONE;
            neg = q_side.spec_neg;
        end else begin
            mag = q_side.den_zero ? '0 : q_quo;
            neg = dsg_pkg::num_neg(q_side.idx) ^ q_side.den_neg;
        end
        neg = neg ^ q_side.flip;
        if (mag == '0) begin
            neg = 1'b0;
        end
        if (neg) begin
            clip = (mag > MAG_ONE) ? MAG_ONE : mag;
            wide = FMT_W'(0) - FMT_W'(clip);
        end else begin
            clip = (mag > MAG_ONE - MAG_W'(1)) ? MAG_ONE - MAG_W'(1) : mag;
            wide = FMT_W'(clip);
        end
        n_value = q_side.oor ? '0 : wide[dsg_pkg::VALUE_W-1:0];
    end

    // output register and skid register
    logic                        r_out_valid, r_skid_valid;
    logic [dsg_pkg::VALUE_W-1:0] r_out_value, r_skid_value;
    logic                        r_out_oor, r_skid_oor;

    assign en          = !r_skid_valid;
    assign fire        = q_valid && en;
    assign i_req.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || o_rsp.ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= fire;
            end
        end else if (fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || o_rsp.ready) begin
            if (r_skid_valid) begin
                r_out_value <= r_skid_value;
                r_out_oor   <= r_skid_oor;
            end else begin
                r_out_value <= n_value;
                r_out_oor   <= q_side.oor;
            end
        end else if (fire) begin
            r_skid_value <= n_value;
            r_skid_oor   <= q_side.oor;
        end
    end

    assign o_rsp.valid              = r_out_valid;
    assign o_rsp.sample_value       = r_out_value;
    assign o_rsp.index_out_of_range = r_out_oor;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a request while output register is empty");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !o_rsp.ready))
        else $error("skid register filled without a stalled output");

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.index_out_of_range |-> o_rsp.sample_value == '0)
        else $error("out of range index with nonzero sample");
endmodule
`default_nettype wire

FILE: hdl/dsg_div_pipe.sv
// pipelined restoring divider, a fixed number of quotient bits per stage
`default_nettype none
module dsg_div_pipe #(
    parameter int NUM_W = 39,
    parameter int DEN_W = 8,
    parameter int QUO_W = 32,
    parameter int STEPS = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_valid,
    input  wire dsg_pkg::t_side       i_side,
    input  wire logic [NUM_W-1:0]     i_num,
    input  wire logic [DEN_W-1:0]     i_den,
    output logic                      o_valid,
    output dsg_pkg::t_side            o_side,
    output logic [QUO_W-1:0]          o_quo
);
    localparam int NSTG = QUO_W / STEPS;

    logic [NSTG-1:0]   r_valid;
    dsg_pkg::t_side    r_side [NSTG];
    logic [DEN_W-1:0]  r_rem  [NSTG];
    logic [DEN_W-1:0]  r_den  [NSTG];
    logic [QUO_W-1:0]  r_low  [NSTG];
    logic [QUO_W-1:0]  r_quo  [NSTG];

    for (genvar s = 0; s < NSTG; s++) begin : g_stg
        logic             src_valid;
        dsg_pkg::t_side   src_side;
        logic [DEN_W-1:0] src_rem, src_den, n_rem;
        logic [QUO_W-1:0] src_low, src_quo, n_low, n_quo;

        if (s == 0) begin : g_first
            assign src_valid = i_valid;
            assign src_side  = i_side;
            assign src_rem   = DEN_W'(i_num >> QUO_W);
            assign src_den   = i_den;
            assign src_low   = i_num[QUO_W-1:0];
            assign src_quo   = '0;
        end else begin : g_next
            assign src_valid = r_valid[s-1];
            assign src_side  = r_side[s-1];
            assign src_rem   = r_rem[s-1];
            assign src_den   = r_den[s-1];
            assign src_low   = r_low[s-1];
            assign src_quo   = r_quo[s-1];
        end

        always_comb begin
            logic [DEN_W:0] cat;
            n_rem = src_rem;
            n_low = src_low;
            n_quo = src_quo;
            for (int k = 0; k < STEPS; k++) begin
                cat   = {n_rem, n_low[QUO_W-1]};
                n_low = n_low << 1;
                if (cat >= {1'b0, src_den}) begin
                    n_rem = DEN_W'(cat - {1'b0, src_den});
                    n_quo = {n_quo[QUO_W-2:0], 1'b1};
                end else begin
                    n_rem = cat[DEN_W-1:0];
                    n_quo = {n_quo[QUO_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (i_en) begin
                r_valid[s] <= src_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[s] <= src_side;
                r_rem[s]  <= n_rem;
                r_den[s]  <= src_den;
                r_low[s]  <= n_low;
                r_quo[s]  <= n_quo;
            end
        end
    end

    assign o_valid = r_valid[NSTG-1];
    assign o_side  = r_side[NSTG-1];
    assign o_quo   = r_quo[NSTG-1];
endmodule
`default_nettype wire

FILE: hdl/dsg_horner.sv
// one horner step of the sine series: multiply, reciprocal divide, subtract
`default_nettype none
module dsg_horner #(
    parameter int STEP = 0
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic                         i_valid,
    input  wire dsg_pkg::t_side               i_side,
    input  wire logic [dsg_pkg::X_W-1:0]      i_x,
    input  wire logic [dsg_pkg::X2_W-1:0]     i_x2,
    input  wire logic [dsg_pkg::R_W-1:0]      i_r,
    output logic                              o_valid,
    output dsg_pkg::t_side                    o_side,
    output logic [dsg_pkg::X_W-1:0]           o_x,
    output logic [dsg_pkg::X2_W-1:0]          o_x2,
    output logic [dsg_pkg::R_W-1:0]           o_r
);
    localparam logic [dsg_pkg::HC_W-1:0] HC = dsg_pkg::horner_div(STEP);
    localparam logic [dsg_pkg::HQ_W-1:0] HM = dsg_pkg::horner_recip(STEP);
    localparam int P_W = dsg_pkg::X2_W + dsg_pkg::R_W;
    localparam int M_W = dsg_pkg::X2_W + dsg_pkg::HQ_W;
    localparam int C_W = dsg_pkg::HQ_W + dsg_pkg::HC_W;

    // stage a: x2 * r
    logic                         r_a_valid;
    dsg_pkg::t_side               r_a_side;
    logic [dsg_pkg::X_W-1:0]      r_a_x;
    logic [dsg_pkg::X2_W-1:0]     r_a_x2, r_a_v;
    // stage b: reciprocal product
    logic                         r_b_valid;
    dsg_pkg::t_side               r_b_side;
    logic [dsg_pkg::X_W-1:0]      r_b_x;
    logic [dsg_pkg::X2_W-1:0]     r_b_x2, r_b_v;
    logic [dsg_pkg::HQ_W-1:0]     r_b_q;
    // stage c: correction and subtract
    logic                         r_c_valid;
    dsg_pkg::t_side               r_c_side;
    logic [dsg_pkg::X_W-1:0]      r_c_x;
    logic [dsg_pkg::X2_W-1:0]     r_c_x2;
    logic [dsg_pkg::R_W-1:0]      r_c_r;

    logic [P_W-1:0]               prod_a;
    logic [M_W-1:0]               prod_b;
    logic [C_W-1:0]               qc;
    logic [dsg_pkg::X2_W-1:0]     rem;
    logic [dsg_pkg::R_W-1:0]      t, n_r;

    assign prod_a = P_W'(i_x2) * P_W'(i_r);
    assign prod_b = M_W'(r_a_v) * M_W'(HM);

    always_comb begin
        qc  = C_W'(r_b_q) * C_W'(HC);
        rem = r_b_v - qc[dsg_pkg::X2_W-1:0];
        t   = dsg_pkg::R_W'(r_b_q) + dsg_pkg::R_W'(rem >= dsg_pkg::X2_W'(HC));
        n_r = (t >= dsg_pkg::ONE_Q30) ? '0 : dsg_pkg::ONE_Q30 - t;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_side <= i_side;
            r_a_x    <= i_x;
            r_a_x2   <= i_x2;
            r_a_v    <= prod_a[dsg_pkg::Q +: dsg_pkg::X2_W];
            r_b_side <= r_a_side;
            r_b_x    <= r_a_x;
            r_b_x2   <= r_a_x2;
            r_b_v    <= r_a_v;
            r_b_q    <= prod_b[dsg_pkg::X2_W +: dsg_pkg::HQ_W];
            r_c_side <= r_b_side;
            r_c_x    <= r_b_x;
            r_c_x2   <= r_b_x2;
            r_c_r    <= n_r;
        end
    end

    assign o_valid = r_c_valid;
    assign o_side  = r_c_side;
    assign o_x     = r_c_x;
    assign o_x2    = r_c_x2;
    assign o_r     = r_c_r;
endmodule
`default_nettype wire

FILE: hdl/dsg_front.sv
// index decode, angle folding and angle numerator
`default_nettype none
module dsg_front #(
    parameter int MAX_ORDER = dsg_pkg::DEF_MAX_ORDER
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire logic [dsg_pkg::INDEX_W-1:0]   i_sample_index,
    input  wire logic [dsg_pkg::ORDER_W-1:0]   i_order,
    input  wire logic                          i_shifted_mode,
    output logic                               o_valid,
    output dsg_pkg::t_side                     o_side,
    output logic [dsg_pkg::ANG_W-1:0]          o_ang,
    output logic [dsg_pkg::N4_W-1:0]           o_n4
);
    logic [dsg_pkg::ORDER_W-1:0] n;
    logic [dsg_pkg::N4_W-1:0]    n4, j, kk_raw;
    logic [dsg_pkg::INDEX_W-1:0] n8;
    logic                        first_half;
    dsg_pkg::t_side              side;

    logic                        r_valid0;
    dsg_pkg::t_side              r_side0;
    logic [dsg_pkg::KK_W-1:0]    r_kk;

    logic                        r_valid1;
    dsg_pkg::t_side              r_side1;
    logic [dsg_pkg::ANG_W-1:0]   r_ang;
    logic [dsg_pkg::N4_W-1:0]    r_n4;

    always_comb begin
        n = i_order;
        if (i_order == '0) begin
            n = dsg_pkg::ORDER_W'(1);
        end else if (int'(i_order) > MAX_ORDER) begin
            n = dsg_pkg::ORDER_W'(MAX_ORDER);
        end
        n4         = {n, 2'b00};
        n8         = {n, 3'b000};
        first_half = i_sample_index < dsg_pkg::INDEX_W'(n4);
        j = first_half ? dsg_pkg::N4_W'(dsg_pkg::INDEX_W'(n4) - i_sample_index)
                       : dsg_pkg::N4_W'(i_sample_index - dsg_pkg::INDEX_W'(n4));

        side      = '0;
        side.n    = n;
        side.oor  = i_sample_index > n8;
        side.flip = !i_shifted_mode && first_half && !n[0];
        kk_raw    = j;
        if (i_shifted_mode) begin
            if (j == '0) begin
                side.special = 1'b1;
            end else if (j == n4) begin
                side.special  = 1'b1;
                side.spec_neg = !n[0];
            end
            side.idx = j[2:0];
        end else begin
            if (j == dsg_pkg::N4_W'(2)) begin
                side.special = 1'b1;
                kk_raw       = '0;
                side.idx     = '0;
            end else if (j < dsg_pkg::N4_W'(2)) begin
                kk_raw       = dsg_pkg::N4_W'(2) - j;
                side.den_neg = 1'b1;
                side.idx     = j[2:0] + 3'd6;
            end else begin
                kk_raw   = j - dsg_pkg::N4_W'(2);
                side.idx = kk_raw[2:0];
            end
        end
        // fold into the first quarter wave
        if ({kk_raw, 1'b0} > {1'b0, n4}) begin
            kk_raw = n4 - kk_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid0 <= 1'b0;
            r_valid1 <= 1'b0;
        end else if (i_en) begin
            r_valid0 <= i_valid;
            r_valid1 <= r_valid0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side0 <= side;
            r_kk    <= kk_raw[dsg_pkg::KK_W-1:0];
            r_side1 <= r_side0;
            r_ang   <= dsg_pkg::ANG_W'(dsg_pkg::PI_Q30) * dsg_pkg::ANG_W'(r_kk)
                     + dsg_pkg::ANG_W'({r_side0.n, 1'b0});
            r_n4    <= {r_side0.n, 2'b00};
        end
    end

    assign o_valid = r_valid1;
    assign o_side  = r_side1;
    assign o_ang   = r_ang;
    assign o_n4    = r_n4;
endmodule
`default_nettype wire

FILE: tb/sv/tb_digital_sinc_sample_generator_core.sv
// testbench for the digital sinc sample generator: directed and random indexes vs a predictor
`default_nettype none
module tb_digital_sinc_sample_generator_core;

    localparam int LATENCY     = 40 + dsg_pkg::DEF_FRAC_BITS;
    localparam int CYCLE_LIMIT = 400000;
    localparam longint unsigned PI_Q = 64'd3373259426;
    localparam longint unsigned ONE_Q = 64'd1 << 30;
    localparam longint unsigned HS2_Q = 64'd759250125;

    typedef struct packed {
        logic [dsg_pkg::VALUE_W-1:0] sample_value;
        logic                        index_out_of_range;
    } t_sample;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [dsg_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [dsg_pkg::ORDER_W-1:0] i_cfg_wdata = '0;

    dsg_req_if req ();
    dsg_rsp_if rsp ();

    digital_sinc_sample_generator_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req),
        .o_rsp       (rsp)
    );

    always #4 i_clk = ~i_clk;

    logic [dsg_pkg::ORDER_W-1:0] cur_order = 6'd1;
    logic               cur_symmetric = 1'b1;
    t_sample            pending_samples[$];
    int                 n_errors = 0;
    int                 cycles = 0;
    int                 rsp_stall = 0;
    bit                 busy_mode = 1'b0;

    initial begin
        req.valid = 1'b0;
        req.sample_index = '0;
        rsp.ready = 1'b0;
    end

    function automatic longint unsigned sine_q30(longint unsigned k, longint unsigned n4);
        longint unsigned x, x2, r, t;
        longint unsigned divs[8];
        divs = '{272, 210, 156, 110, 72, 42, 20, 6};
        x = (PI_Q * k + n4 / 2) / n4;
        x2 = (x * x) >> 30;
        r = ONE_Q;
        for (int i = 0; i < 8; i++) begin
            t = ((x2 * r) >> 30) / divs[i];
            r = (t >= ONE_Q) ? 0 : ONE_Q - t;
        end
        return (x * r) >> 30;
    endfunction

    function automatic t_sample dirichlet_sample(logic [dsg_pkg::INDEX_W-1:0] m_in,
                                                 logic [dsg_pkg::ORDER_W-1:0] n_reg,
                                                 logic symmetric);
        t_sample s;
        longint unsigned n, n4, m, j, kk, den, mag;
        longint unsigned nmag;
        bit first_half, neg, den_neg, special;
        int idx;
        n = n_reg;
        if (n < 1) n = 1;
        if (n > dsg_pkg::DEF_MAX_ORDER) n = dsg_pkg::DEF_MAX_ORDER;
        n4 = 4 * n;
        m = m_in;
        neg = 0; den_neg = 0; special = 0; kk = 0; idx = 0;
        if (m > 2 * n4) begin
            s.sample_value = '0;
            s.index_out_of_range = 1'b1;
            return s;
        end
        first_half = m < n4;
        j = first_half ? n4 - m : m - n4;
        if (symmetric) begin
            if (j == 0) special = 1;
            else if (j == n4) begin
                special = 1;
                neg = (n % 2) == 0;
            end
            kk = j;
            idx = int'(j % 8);
        end else if (j == 2) begin
            special = 1;
        end else if (j < 2) begin
            kk = 2 - j;
            den_neg = 1;
            idx = int'((j + 6) % 8);
        end else begin
            kk = j - 2;
            idx = int'((j - 2) % 8);
        end
        if (special) mag = 64'd1 << dsg_pkg::DEF_FRAC_BITS;
        else begin
            if (2 * kk > n4) kk = n4 - kk;
            den = n * sine_q30(kk, n4);
            nmag = (idx % 4 == 0) ? 0 : (idx % 4 == 2) ? ONE_Q : HS2_Q;
            mag = (den == 0) ? 0 : ((nmag << dsg_pkg::DEF_FRAC_BITS) + den / 2) / den;
            neg = (idx >= 5) != den_neg;
        end
        if (!symmetric && first_half && (n % 2) == 0) neg = !neg;
        if (mag == 0) neg = 0;
        if (neg) begin
            if (mag > (64'd1 << dsg_pkg::DEF_FRAC_BITS)) mag = 64'd1 << dsg_pkg::DEF_FRAC_BITS;
            s.sample_value = dsg_pkg::VALUE_W'(-mag);
        end else begin
            if (mag > (64'd1 << dsg_pkg::DEF_FRAC_BITS) - 1)
                mag = (64'd1 << dsg_pkg::DEF_FRAC_BITS) - 1;
            s.sample_value = dsg_pkg::VALUE_W'(mag);
        end
        s.index_out_of_range = 1'b0;
        return s;
    endfunction

    // response side backpressure
    always @(negedge i_clk) begin
        rsp.ready <= (rsp_stall == 0);
        if (rsp_stall > 0) rsp_stall--;
    end

    always @(posedge i_clk) begin
        t_sample exp_s;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
        if (i_rst_n && rsp.valid && rsp.ready) begin
            rsp_stall = busy_mode ? $urandom_range(0, 5) : 0;
            if (pending_samples.size() == 0) begin
                $error("unexpected result value %0d", $signed(rsp.sample_value));
                n_errors++;
            end else begin
                exp_s = pending_samples.pop_front();
                if (rsp.sample_value !== exp_s.sample_value) begin
                    $error("sample_value expected %0d actual %0d",
                           $signed(exp_s.sample_value), $signed(rsp.sample_value));
                    n_errors++;
                end
                if (rsp.index_out_of_range !== exp_s.index_out_of_range) begin
                    $error("index_out_of_range expected %0b actual %0b",
                           exp_s.index_out_of_range, rsp.index_out_of_range);
                    n_errors++;
                end
            end
        end
    end

    // called at a falling edge, returns at a falling edge with valid still high
    task automatic send_index(input logic [dsg_pkg::INDEX_W-1:0] m);
        int gap;
        gap = busy_mode ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req.valid <= 1'b1;
        req.sample_index <= m;
        while (!req.ready) @(negedge i_clk);
        @(posedge i_clk);
        pending_samples.push_back(dirichlet_sample(m, cur_order, cur_symmetric));
        @(negedge i_clk);
    endtask

    task automatic drain;
        req.valid <= 1'b0;
        while (pending_samples.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [dsg_pkg::CFG_IDX_W-1:0] index,
                             input logic [dsg_pkg::ORDER_W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (index == dsg_pkg::CFG_ORDER) cur_order = value;
        else cur_symmetric = value[0];
    endtask

    task automatic set_kernel(input logic [dsg_pkg::ORDER_W-1:0] n, input logic symmetric);
        drain();
        write_cfg(dsg_pkg::CFG_ORDER, n);
        write_cfg(dsg_pkg::CFG_SHIFTED_MODE, dsg_pkg::ORDER_W'(symmetric));
    endtask

    function automatic int eff_order(logic [dsg_pkg::ORDER_W-1:0] n);
        return (n == 0) ? 1 : (int'(n) > dsg_pkg::DEF_MAX_ORDER) ? dsg_pkg::DEF_MAX_ORDER
                                                                 : int'(n);
    endfunction

    // reset defaults, end points, center and just past the end
    task automatic test_reset_defaults;
        busy_mode = 1'b0;
        for (int m = 0; m <= 9; m++) send_index(dsg_pkg::INDEX_W'(m));
        send_index(9'd511);
    endtask

    task automatic test_shifted_large;
        set_kernel(6'd32, 1'b0);
        busy_mode = 1'b1;
        send_index(9'd0);
        send_index(9'd126);
        send_index(9'd127);
        send_index(9'd128);
        send_index(9'd130);
        send_index(9'd131);
        send_index(9'd256);
        send_index(9'd257);
    endtask

    task automatic test_order_clamp;
        set_kernel(6'd0, 1'b0);
        for (int m = 0; m <= 9; m++) send_index(dsg_pkg::INDEX_W'(m));
        set_kernel(6'd63, 1'b1);
        send_index(9'd0);
        send_index(9'd128);
        send_index(9'd256);
        send_index(9'd257);
        send_index(9'd511);
    endtask

    task automatic test_random_sweep(input int phases, input int per_phase);
        logic [dsg_pkg::ORDER_W-1:0] n;
        logic sym;
        int top;
        for (int p = 0; p < phases; p++) begin
            case (p % 6)
                0: n = 6'd1;
                1: n = 6'd32;
                2: n = 6'd2;
                3: n = dsg_pkg::ORDER_W'($urandom_range(1, 8));
                default: n = dsg_pkg::ORDER_W'($urandom_range(0, 63));
            endcase
            sym = 1'($urandom_range(0, 1));
            set_kernel(n, sym);
            busy_mode = (p % 4 != 3);
            top = 8 * eff_order(n);
            for (int i = 0; i < per_phase; i++) begin
                if ($urandom_range(0, 9) == 0)
                    send_index(dsg_pkg::INDEX_W'($urandom_range(0, 511)));
                else
                    send_index(dsg_pkg::INDEX_W'($urandom_range(0, top)));
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_reset_defaults();
        test_shifted_large();
        test_order_clamp();
        test_random_sweep(12, 63);
        drain();
        if (n_errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

FILE: digital_sinc_sample_generator_core.f
hdl/dsg_pkg.sv
hdl/dsg_req_if.sv
hdl/dsg_rsp_if.sv
hdl/dsg_div_pipe.sv
hdl/dsg_horner.sv
hdl/dsg_front.sv
hdl/digital_sinc_sample_generator_core.sv
tb/sv/tb_digital_sinc_sample_generator_core.sv
